[rtl/sdf_pkg.sv]
// Shared constants, types and helpers of the signed decimal formatter.
`default_nettype none
package sdf_pkg;

  localparam int MAX_PRECISION_DEF = 48;
  localparam int DATA_WIDTH_DEF    = 32;
  localparam int PREC_IN_W         = 7;
  localparam int CHAR_W            = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_MINUS,
    SIGN_PLUS,
    SIGN_SPACE
  } sign_t;

  // classification that travels with each item from front to back
  typedef struct packed {
    sign_t sign;
    logic  zero_digit;
  } fmt_ctrl_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SCAN,
    B_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] sign_char(input sign_t s);
    logic [CHAR_W-1:0] c;
    case (s)
      SIGN_MINUS: c = CH_MINUS;
      SIGN_PLUS:  c = CH_PLUS;
      SIGN_SPACE: c = CH_SPACE;
      default:    c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/sdf_front.sv]
// Front end: magnitude, sign choice and precision clamp of an incoming item.
`default_nettype none
module sdf_front #(
  parameter int MAX_PRECISION = sdf_pkg::MAX_PRECISION_DEF,
  parameter int DATA_WIDTH    = sdf_pkg::DATA_WIDTH_DEF,
  localparam int PREC_W       = $clog2(MAX_PRECISION + 1)
) (
  input  wire logic signed [DATA_WIDTH-1:0]         value,
  input  wire logic signed [sdf_pkg::PREC_IN_W-1:0] precision,
  input  wire logic                                 force_plus,
  input  wire logic                                 space_pad,
  output logic             [DATA_WIDTH-1:0]         magnitude,
  output logic             [PREC_W-1:0]             pad,
  output sdf_pkg::fmt_ctrl_t                        ctrl
);

  logic [DATA_WIDTH-1:0] v;
  logic                  neg;

  assign v   = value;
  assign neg = v[DATA_WIDTH-1];

  // two's complement magnitude; the most negative value fits unsigned
  assign magnitude = neg ? (~v + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : v;

  // negative precision means no padding, large precision saturates
  always_comb begin
    if (precision[sdf_pkg::PREC_IN_W-1]) begin
      pad = '0;
    end else if (int'(precision[sdf_pkg::PREC_IN_W-2:0]) > MAX_PRECISION) begin
      pad = PREC_W'(MAX_PRECISION);
    end else begin
      pad = PREC_W'(precision[sdf_pkg::PREC_IN_W-2:0]);
    end
  end

  // minus beats plus beats space; a zero value prints a digit unless precision is exactly zero
  always_comb begin
    ctrl.zero_digit = (precision != '0);
    if (neg) begin
      ctrl.sign = sdf_pkg::SIGN_MINUS;
    end else if (force_plus) begin
      ctrl.sign = sdf_pkg::SIGN_PLUS;
    end else if (space_pad) begin
      ctrl.sign = sdf_pkg::SIGN_SPACE;
    end else begin
      ctrl.sign = sdf_pkg::SIGN_NONE;
    end
  end

endmodule
`default_nettype wire

[rtl/sdf_queue.sv]
// Short first-in first-out queue between front and back.
`default_nettype none
module sdf_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int DEPTH = sdf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill-level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/sdf_back.sv]
// Back end: bit-serial binary to BCD conversion and character emission.
`default_nettype none
module sdf_back #(
  parameter int MAX_PRECISION = sdf_pkg::MAX_PRECISION_DEF,
  parameter int DATA_WIDTH    = sdf_pkg::DATA_WIDTH_DEF,
  localparam int PREC_W       = $clog2(MAX_PRECISION + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic [DATA_WIDTH-1:0]       item_mag,
  input  wire logic [PREC_W-1:0]           item_pad,
  input  wire sdf_pkg::fmt_ctrl_t          item_ctrl,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sdf_pkg::CHAR_W-1:0]       out_character,
  output logic                             out_char_valid,
  output logic                             out_last
);

  // decimal digits needed for 2^DATA_WIDTH - 1
  localparam int ND     = (DATA_WIDTH * 301) / 1000 + 1;
  localparam int DIDX_W = $clog2(ND);
  localparam int MAXLEN = ((MAX_PRECISION > ND) ? MAX_PRECISION : ND) + 1;
  localparam int CNT_W  = $clog2(MAXLEN + 1);
  localparam int BIT_W  = $clog2(DATA_WIDTH + 1);

  sdf_pkg::back_state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] sh_r, sh_nxt;
  logic [ND*4-1:0]       bcd_r, bcd_nxt;
  logic [ND*4-1:0]       bcd_adj;
  logic [BIT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [PREC_W-1:0]     pad_r, pad_nxt;
  sdf_pkg::fmt_ctrl_t    ctrl_r, ctrl_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic [CNT_W-1:0]      zcnt_r, zcnt_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [DIDX_W-1:0]     didx_r, didx_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [sdf_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                        out_cv_r, out_cv_nxt;
  logic                        out_last_r, out_last_nxt;

  logic             slot_free;
  logic [CNT_W-1:0] nd_c, nd_raw, zeros_c, pad_ext, total_c, nd_m1;
  logic [3:0]       cur_digit;

  assign item_ready     = (state_r == sdf_pkg::B_IDLE);
  assign slot_free      = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_last       = out_last_r;

  // add-3 correction of every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  // significant digit count, padding zeros and text length
  always_comb begin
    nd_raw = '0;
    for (int i = 0; i < ND; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        nd_raw = CNT_W'(i + 1);
      end
    end
    nd_c    = (nd_raw == '0 && ctrl_r.zero_digit) ? CNT_W'(1) : nd_raw;
    pad_ext = CNT_W'(pad_r);
    zeros_c = (pad_ext > nd_c) ? pad_ext - nd_c : '0;
    total_c = zeros_c + nd_c
            + CNT_W'(ctrl_r.sign != sdf_pkg::SIGN_NONE);
    nd_m1   = nd_c - 1'b1;
  end

  assign cur_digit = bcd_r[didx_r*4 +: 4];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdf_pkg::B_IDLE: begin
        if (item_valid) state_nxt = sdf_pkg::B_CONV;
      end
      sdf_pkg::B_CONV: begin
        if (bit_cnt_r == BIT_W'(1)) state_nxt = sdf_pkg::B_SCAN;
      end
      sdf_pkg::B_SCAN: begin
        state_nxt = sdf_pkg::B_EMIT;
      end
      sdf_pkg::B_EMIT: begin
        if (slot_free && (rem_r == '0 || rem_r == CNT_W'(1))) begin
          state_nxt = sdf_pkg::B_IDLE;
        end
      end
      default: state_nxt = sdf_pkg::B_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    sh_nxt        = sh_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    pad_nxt       = pad_r;
    ctrl_nxt      = ctrl_r;
    sign_pend_nxt = sign_pend_r;
    zcnt_nxt      = zcnt_r;
    rem_nxt       = rem_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      sdf_pkg::B_IDLE: begin
        if (item_valid) begin
          sh_nxt      = item_mag;
          bcd_nxt     = '0;
          bit_cnt_nxt = BIT_W'(DATA_WIDTH);
          pad_nxt     = item_pad;
          ctrl_nxt    = item_ctrl;
        end
      end
      sdf_pkg::B_CONV: begin
        bcd_nxt     = {bcd_adj[ND*4-2:0], sh_r[DATA_WIDTH-1]};
        sh_nxt      = {sh_r[DATA_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
      end
      sdf_pkg::B_SCAN: begin
        sign_pend_nxt = (ctrl_r.sign != sdf_pkg::SIGN_NONE);
        zcnt_nxt      = zeros_c;
        rem_nxt       = total_c;
        didx_nxt      = nd_m1[DIDX_W-1:0];
      end
      sdf_pkg::B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (rem_r == '0) begin
            // empty text: one filler transfer
            out_char_nxt = sdf_pkg::CH_NUL;
            out_cv_nxt   = 1'b0;
            out_last_nxt = 1'b1;
          end else begin
            out_cv_nxt   = 1'b1;
            out_last_nxt = (rem_r == CNT_W'(1));
            rem_nxt      = rem_r - 1'b1;
            if (sign_pend_r) begin
              out_char_nxt  = sdf_pkg::sign_char(ctrl_r.sign);
              sign_pend_nxt = 1'b0;
            end else if (zcnt_r != '0) begin
              out_char_nxt = sdf_pkg::CH_ZERO;
              zcnt_nxt     = zcnt_r - 1'b1;
            end else begin
              out_char_nxt = sdf_pkg::CH_ZERO + {4'd0, cur_digit};
              didx_nxt     = didx_r - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    bcd_r       <= bcd_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    pad_r       <= pad_nxt;
    ctrl_r      <= ctrl_nxt;
    sign_pend_r <= sign_pend_nxt;
    zcnt_r      <= zcnt_nxt;
    rem_r       <= rem_nxt;
    didx_r      <= didx_nxt;
    out_char_r  <= out_char_nxt;
    out_cv_r    <= out_cv_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
`default_nettype wire

[rtl/signed_decimal_formatter.sv]
// An item crosses the queue and the back end's CONV and SCAN states before its first
// character is registered. The back end converts with a one-bit-per-cycle binary to BCD
// shift, then emits 1 .. MAX_PRECISION + 1 transfers, one a cycle unless out_ready stalls.
// A two-entry queue lets the next items be taken while the back end is busy.
// Synchronous active-low reset empties the queue, idles the back end, drops the output.
`default_nettype none
module signed_decimal_formatter #(
  parameter int MAX_PRECISION = sdf_pkg::MAX_PRECISION_DEF,
  parameter int DATA_WIDTH    = sdf_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]         in_value,
  input  wire logic signed [sdf_pkg::PREC_IN_W-1:0] in_precision,
  input  wire logic                                 in_force_plus,
  input  wire logic                                 in_space_pad,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [sdf_pkg::CHAR_W-1:0]    out_character,
  output logic                                      out_char_valid,
  output logic                                      out_last
);

  localparam int PREC_W = $clog2(MAX_PRECISION + 1);
  localparam int CTRL_W = $bits(sdf_pkg::fmt_ctrl_t);
  localparam int Q_W    = DATA_WIDTH + PREC_W + CTRL_W;

  logic [DATA_WIDTH-1:0] f_mag, b_mag;
  logic [PREC_W-1:0]     f_pad, b_pad;
  sdf_pkg::fmt_ctrl_t    f_ctrl, b_ctrl;
  logic [Q_W-1:0]        q_push_data, q_pop_data;
  logic                  q_pop_valid, q_pop_ready;

  // classify the incoming item
  sdf_front #(
    .MAX_PRECISION(MAX_PRECISION),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_front (
    .value     (in_value),
    .precision (in_precision),
    .force_plus(in_force_plus),
    .space_pad (in_space_pad),
    .magnitude (f_mag),
    .pad       (f_pad),
    .ctrl      (f_ctrl)
  );

  assign q_push_data = {f_mag, f_pad, f_ctrl};

  sdf_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_valid),
    .push_ready(in_ready),
    .push_data (q_push_data),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  assign {b_mag, b_pad, b_ctrl} = q_pop_data;

  // convert and emit
  sdf_back #(
    .MAX_PRECISION(MAX_PRECISION),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (q_pop_valid),
    .item_ready    (q_pop_ready),
    .item_mag      (b_mag),
    .item_pad      (b_pad),
    .item_ctrl     (b_ctrl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_char_valid(out_char_valid),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

[test/sdf_text_checker.sv]
// Checker for the signed decimal formatter: predicts the text of each value and compares it.
module sdf_text_checker
  import sdf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [31:0]         in_value,
  input  logic signed [PREC_IN_W-1:0] in_precision,
  input  logic                       in_force_plus,
  input  logic                       in_space_pad,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic        [CHAR_W-1:0]   out_character,
  input  logic                       out_char_valid,
  input  logic                       out_last,
  output int                         fail_count,
  output int                         chars_waiting,
  output int                         values_taken,
  output int                         chars_taken,
  output int                         empty_taken
);

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              char_valid;
    logic              last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t owed_text[$];
  text_char_t got;
  int         n_fail   = 0;
  int         n_values = 0;
  int         n_chars  = 0;
  int         n_empty  = 0;

  initial begin
    fail_count    = 0;
    chars_waiting = 0;
    values_taken  = 0;
    chars_taken   = 0;
    empty_taken   = 0;
  end

  // queue one character of the expected text
  function automatic void owe_char(input logic [CHAR_W-1:0] ch, input logic valid,
                                   input logic is_last);
    text_char_t c;
    c.character  = ch;
    c.char_valid = valid;
    c.last       = is_last;
    owed_text.push_back(c);
  endfunction

  // work out the printf-style text of one value and queue it
  function automatic void format_decimal(input logic [31:0] value,
                                         input logic signed [PREC_IN_W-1:0] prec_in,
                                         input logic plus_flag, input logic space_flag);
    logic              negative;
    logic [31:0]       magnitude;
    int                prec;
    int                n_digits;
    int                pad_zeros;
    int                total;
    int                pos;
    logic [3:0]        digit [10];
    sign_t             sign;
    logic [CHAR_W-1:0] sign_ch;
    negative  = value[31];
    magnitude = negative ? (~value + 32'd1) : value;
    prec      = int'(prec_in);
    if (prec > MAX_PRECISION_DEF) prec = MAX_PRECISION_DEF;

    // digits, least significant first; zero only has a digit when precision is not 0
    n_digits = 0;
    if (magnitude == 32'd0) begin
      if (prec != 0) begin
        digit[0] = 4'd0;
        n_digits = 1;
      end
    end else begin
      while (magnitude != 32'd0) begin
        digit[n_digits] = 4'(magnitude % 32'd10);
        magnitude       = magnitude / 32'd10;
        n_digits++;
      end
    end
    pad_zeros = (prec > n_digits) ? prec - n_digits : 0;

    // minus beats plus, plus beats space
    if (negative)        sign = SIGN_MINUS;
    else if (plus_flag)  sign = SIGN_PLUS;
    else if (space_flag) sign = SIGN_SPACE;
    else                 sign = SIGN_NONE;
    case (sign)
      SIGN_MINUS: sign_ch = CH_MINUS;
      SIGN_PLUS:  sign_ch = CH_PLUS;
      SIGN_SPACE: sign_ch = CH_SPACE;
      default:    sign_ch = CH_NUL;
    endcase

    total = ((sign != SIGN_NONE) ? 1 : 0) + pad_zeros + n_digits;
    if (total == 0) begin
      // empty text: a single filler marked not valid
      owe_char(CH_NUL, 1'b0, 1'b1);
      return;
    end
    pos = 0;
    if (sign != SIGN_NONE) begin
      owe_char(sign_ch, 1'b1, pos == total - 1);
      pos++;
    end
    for (int z = 0; z < pad_zeros; z++) begin
      owe_char(CH_ZERO, 1'b1, pos == total - 1);
      pos++;
    end
    for (int d = n_digits - 1; d >= 0; d--) begin
      owe_char(CH_ZERO + CHAR_W'(digit[d]), 1'b1, pos == total - 1);
      pos++;
    end
  endfunction

  // watch both channels; input transfers are predicted before results are compared
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        format_decimal(in_value, in_precision, in_force_plus, in_space_pad);
        n_values++;
      end
      if (out_valid && out_ready) begin
        n_chars++;
        if (!out_char_valid) n_empty++;
        if (owed_text.size() == 0) begin
          $error("unexpected character transfer: character %h char_valid %b last %b",
                 out_character, out_char_valid, out_last);
          n_fail++;
        end else begin
          got = owed_text.pop_front();
          if (out_character !== got.character) begin
            $error("character: expected %h, got %h", got.character, out_character);
            n_fail++;
          end
          if (out_char_valid !== got.char_valid) begin
            $error("char_valid: expected %b, got %b", got.char_valid, out_char_valid);
            n_fail++;
          end
          if (out_last !== got.last) begin
            $error("last: expected %b, got %b", got.last, out_last);
            n_fail++;
          end
        end
      end
    end
    fail_count    <= n_fail;
    chars_waiting <= owed_text.size();
    values_taken  <= n_values;
    chars_taken   <= n_chars;
    empty_taken   <= n_empty;
  end

endmodule

[test/signed_decimal_formatter_tb.sv]
// Testbench top for the signed decimal formatter: stimulus, back-pressure and verdict.
module signed_decimal_formatter_tb;
  import sdf_pkg::*;

  localparam int          NUM_RANDOM  = 196;
  localparam int          CALM_ITEMS  = 40;
  localparam int          SETTLE      = 60;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [31:0]           in_value;
  logic signed [PREC_IN_W-1:0]  in_precision;
  logic                         in_force_plus;
  logic                         in_space_pad;
  logic                         out_valid;
  logic                         out_ready = 1'b1;
  logic        [CHAR_W-1:0]     out_character;
  logic                         out_char_valid;
  logic                         out_last;

  logic        calm = 1'b0;
  int          fail_count;
  int          chars_waiting;
  int          values_taken;
  int          chars_taken;
  int          empty_taken;
  int unsigned cycle_count = 0;
  int          stall_left  = 0;
  int          run_left    = 0;
  logic        ready_next;

  signed_decimal_formatter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_precision   (in_precision),
    .in_force_plus  (in_force_plus),
    .in_space_pad   (in_space_pad),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_char_valid (out_char_valid),
    .out_last       (out_last)
  );

  sdf_text_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_precision   (in_precision),
    .in_force_plus  (in_force_plus),
    .in_space_pad   (in_space_pad),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_char_valid (out_char_valid),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .chars_waiting  (chars_waiting),
    .values_taken   (values_taken),
    .chars_taken    (chars_taken),
    .empty_taken    (empty_taken)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: bursts of stall between runs of ready, none once calm
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      ready_next = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      ready_next = 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      ready_next = 1'b0;
    end else begin
      run_left   = $urandom_range(1, 60);
      ready_next = 1'b1;
    end
    out_ready <= ready_next;
  end

  // one value transfer, with an occasional idle burst ahead of it
  task automatic send_value(input int value, input int prec, input bit plus_flag,
                            input bit space_flag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= value;
    in_precision  <= PREC_IN_W'(prec);
    in_force_plus <= plus_flag;
    in_space_pad  <= space_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every owed character has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
  endtask

  // random value with a bias towards boundaries and short numbers
  task automatic send_random_value();
    int value;
    int prec;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: value = $urandom;
      4, 5:       value = $urandom_range(0, 200) - 100;
      6: begin
        case ($urandom_range(0, 5))
          0:       value = 32'h7FFF_FFFF;
          1:       value = 32'h8000_0000;
          2:       value = 32'h8000_0001;
          3:       value = 0;
          4:       value = -1;
          default: value = 1;
        endcase
      end
      7: begin
        value = 1;
        repeat ($urandom_range(0, 9)) value = value * 10;
        value = value - $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) value = -value;
      end
      default: begin
        value = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) value = -value;
      end
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4, 5: prec = $urandom_range(0, 12) - 1;
      6, 7:             prec = $urandom_range(0, 127);
      8:                prec = $urandom_range(13, 20);
      default:          prec = $urandom_range(40, 63);
    endcase
    send_value(value, prec, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    in_precision  <= '0;
    in_force_plus <= 1'b0;
    in_space_pad  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty text, zero handling, extremes, saturation, sign flags
    send_value(0, 0, 1'b0, 1'b0);
    send_value(0, 0, 1'b1, 1'b0);
    send_value(0, 0, 1'b0, 1'b1);
    send_value(0, 0, 1'b1, 1'b1);
    send_value(0, -1, 1'b0, 1'b0);
    send_value(0, -64, 1'b0, 1'b0);
    send_value(0, -2, 1'b0, 1'b1);
    send_value(0, 1, 1'b0, 1'b0);
    send_value(0, 48, 1'b1, 1'b0);
    send_value(32'h7FFF_FFFF, -1, 1'b0, 1'b0);
    send_value(32'h8000_0000, -1, 1'b1, 1'b1);
    send_value(32'h8000_0000, 63, 1'b0, 1'b0);
    send_value(32'h7FFF_FFFF, 49, 1'b1, 1'b0);
    send_value(-1, 0, 1'b0, 1'b0);
    send_value(1, 48, 1'b0, 1'b1);
    send_value(1234567890, 10, 1'b0, 1'b1);
    send_value(12345, 3, 1'b1, 1'b1);
    send_value(-7, 5, 1'b1, 1'b0);
    send_value(1000000000, 11, 1'b0, 1'b0);
    send_value(9, 0, 1'b0, 1'b0);
    send_value(-10, 2, 1'b0, 1'b1);
    send_value(42, 47, 1'b0, 1'b0);
    send_value(32'h5555_5555, 42, 1'b1, 1'b0);
    send_value(32'hAAAA_AAAA, 21, 1'b0, 1'b0);
    wait_for_drain();

    // random part; a full drain midway, then a calm tail
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) wait_for_drain();
      if (i == NUM_RANDOM - CALM_ITEMS) calm <= 1'b1;
      send_random_value();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Formatted %0d values into %0d character transfers (%0d empty texts).",
             values_taken, chars_taken, empty_taken);
    $display("Directed empty texts, 32-bit extremes, saturated precision and sign flags, %s",
             "then random values under idle bursts and output stalls.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
